/* hdl/assert_macros.svh */
// assertion macros used by the checker file sp24_core_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define SP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define SP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/sp24_pkg.sv */
// package: widths, constants and word types of the 2:4 sparsity compressor
`timescale 1ns / 1ps

package sp24_pkg;

  localparam int ELEM_WIDTH = 16;
  localparam int HALF_ELEMS = 4;
  localparam int NUM_LANES  = 2;
  localparam int POS_WIDTH  = 2;

  // default positions of empty slots, giving an all-empty index byte of 0xEE
  localparam logic [POS_WIDTH-1:0] POS_EMPTY_FIRST  = 2'd2;
  localparam logic [POS_WIDTH-1:0] POS_EMPTY_SECOND = 2'd3;
  localparam logic [POS_WIDTH-1:0] POS_LAST         = 2'd3;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t elem7;
    elem_t elem6;
    elem_t elem5;
    elem_t elem4;
    elem_t elem3;
    elem_t elem2;
    elem_t elem1;
    elem_t elem0;
  } in_word_t;

  typedef struct packed {
    elem_t      kept3;
    elem_t      kept2;
    elem_t      kept1;
    elem_t      kept0;
    logic [7:0] index_byte;
  } out_word_t;

  // what one lane found in its half
  typedef struct packed {
    elem_t                 val0;
    elem_t                 val1;
    logic [POS_WIDTH-1:0]  pos0;
    logic [POS_WIDTH-1:0]  pos1;
  } lane_res_t;

  typedef elem_t [HALF_ELEMS-1:0] half_t;

endpackage

/* hdl/sp24_if.sv */
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface sp24_in_if import sp24_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sp24_out_if import sp24_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sp24_lane.sv */
// one lane: picks the first two nonzero elements of a half group
`timescale 1ns / 1ps

module sp24_lane import sp24_pkg::*; (
  input  half_t     elems,
  output lane_res_t res
);

  logic [HALF_ELEMS-1:0] nz;

  // sign bit ignored, so negative zero counts as zero
  always_comb begin
    for (int p = 0; p < HALF_ELEMS; p++) begin
      nz[p] = |elems[p][ELEM_WIDTH-2:0];
    end
  end

  always_comb begin
    logic [1:0] filled;
    filled   = 2'd0;
    res.val0 = '0;
    res.val1 = '0;
    res.pos0 = POS_EMPTY_FIRST;
    res.pos1 = POS_EMPTY_SECOND;
    for (int p = 0; p < HALF_ELEMS; p++) begin
      if (nz[p] && (filled < 2'd2)) begin
        // lone nonzero at the last position lands in the second slot
        if ((filled == 2'd0) && (POS_WIDTH'(p) == POS_LAST)) begin
          filled = 2'd1;
        end
        if (filled == 2'd0) begin
          res.val0 = elems[p];
          res.pos0 = POS_WIDTH'(p);
        end else begin
          res.val1 = elems[p];
          res.pos1 = POS_WIDTH'(p);
        end
        filled = filled + 2'd1;
      end
    end
  end

endmodule

/* hdl/sp24_merge.sv */
// merge stage: packs lane results into a result word behind a skid buffer
`timescale 1ns / 1ps

module sp24_merge import sp24_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lane_res_t [NUM_LANES-1:0] lane_res,
  sp24_out_if.source              out_ch
);

  out_word_t merged;
  out_word_t main_word;
  out_word_t skid_word;
  logic      main_valid;
  logic      skid_valid;
  logic      in_acc;

  always_comb begin
    merged.kept0      = lane_res[0].val0;
    merged.kept1      = lane_res[0].val1;
    merged.kept2      = lane_res[1].val0;
    merged.kept3      = lane_res[1].val1;
    merged.index_byte = {lane_res[1].pos1, lane_res[1].pos0,
                         lane_res[0].pos1, lane_res[0].pos0};
  end

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ch.ready) begin
      if (skid_valid) begin
        main_word  <= skid_word;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        main_word  <= merged;
        main_valid <= 1'b1;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (in_acc) begin
      // output stalled: park the new word
      skid_word  <= merged;
      skid_valid <= 1'b1;
    end
  end

  assign out_ch.valid = main_valid;
  assign out_ch.data  = main_word;

endmodule

/* hdl/sparse_2of4_compressor_core.sv */
// top level of the 2:4 structured sparsity compressor
//   channel  dir  payload                              handshake
//   in_ch    in   elem0..elem7, 16 bits each           valid/ready
//   out_ch   out  kept0..kept3, 16 bits; index_byte    valid/ready
// one word accepted per cycle while in_ch.ready is high; results are registered
// two selection lanes, one per half, work combinationally into the merge stage
// the merge stage has an output register plus one skid entry, so in_ch.ready
// is a register and drops only after the output has stalled with a word held
// rst is synchronous and clears both valid flags
`timescale 1ns / 1ps

module sparse_2of4_compressor_core import sp24_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sp24_in_if.sink    in_ch,
  sp24_out_if.source out_ch
);

  half_t     [NUM_LANES-1:0] halves;
  lane_res_t [NUM_LANES-1:0] lane_res;

  assign halves[0] = {in_ch.data.elem3, in_ch.data.elem2,
                      in_ch.data.elem1, in_ch.data.elem0};
  assign halves[1] = {in_ch.data.elem7, in_ch.data.elem6,
                      in_ch.data.elem5, in_ch.data.elem4};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sp24_lane u_lane (
      .elems (halves[g]),
      .res   (lane_res[g])
    );
  end

  sp24_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .lane_res (lane_res),
    .out_ch   (out_ch)
  );

endmodule

/* hdl/sp24_core_chk.sv */
// port-level checker for the compressor top, bound to every instance
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sp24_core_chk import sp24_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  logic                 empty0;
  logic                 empty2;
  logic [POS_WIDTH-1:0] pos_s0;
  logic [POS_WIDTH-1:0] pos_s1;
  logic [POS_WIDTH-1:0] pos_s2;
  logic [POS_WIDTH-1:0] pos_s3;
  logic                 empty_ok;
  logic                 order_ok;

  assign empty0 = !(|out_data.kept0[ELEM_WIDTH-2:0]);
  assign empty2 = !(|out_data.kept2[ELEM_WIDTH-2:0]);

  assign pos_s0 = out_data.index_byte[1:0];
  assign pos_s1 = out_data.index_byte[3:2];
  assign pos_s2 = out_data.index_byte[5:4];
  assign pos_s3 = out_data.index_byte[7:6];

  assign empty_ok = (!empty0 || (pos_s0 == POS_EMPTY_FIRST)) &&
                    (!empty2 || (pos_s2 == POS_EMPTY_FIRST));
  assign order_ok = (pos_s1 > pos_s0) && (pos_s3 > pos_s2);

  // stalled result word stays put
  `SP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // back-pressure on the input only after the output was stalled
  `SP_ASSERT_IMP(a_ready_cause, clk, rst, !in_ready, $past(out_valid && !out_ready))
  // an empty first slot carries its default position
  `SP_ASSERT_IMP(a_empty_pos, clk, rst, out_valid, empty_ok)
  // second slot always lies after the first within a half
  `SP_ASSERT_IMP(a_pos_order, clk, rst, out_valid, order_ok)

endmodule

bind sparse_2of4_compressor_core sp24_core_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

/* dv/sparse_2of4_compressor_core_tb.sv */
// testbench for the 2:4 sparsity compressor: random and directed groups checked against a predictor
`timescale 1ns / 1ps

module sparse_2of4_compressor_core_tb;
  import sp24_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sp24_in_if  in_ch ();
  sp24_out_if out_ch ();

  sparse_2of4_compressor_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_word_t  pending_groups[$];
  out_word_t compressed_due[$];

  int  groups_queued = 0;
  int  words_checked = 0;
  int  mismatches    = 0;
  bit  in_taken      = 1'b0;
  int  tx_gap        = 0;
  int  tx_burst      = 0;
  int  rx_stall      = 0;
  int  rx_burst      = 0;
  int  hold_req      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // keeps the first two nonzeros of each half, a lone one at the last position
  // goes to the second slot, and -0 counts as zero
  function automatic out_word_t compress_group(in_word_t w);
    elem_t          elems[8];
    elem_t          vals[4];
    logic [POS_WIDTH-1:0] pos[4];
    out_word_t      r;
    int             filled;
    int             slot;
    elems = '{w.elem0, w.elem1, w.elem2, w.elem3, w.elem4, w.elem5, w.elem6, w.elem7};
    for (int s = 0; s < 4; s++) begin
      vals[s] = '0;
      pos[s]  = (s % 2 == 0) ? POS_EMPTY_FIRST : POS_EMPTY_SECOND;
    end
    for (int h = 0; h < NUM_LANES; h++) begin
      filled = 0;
      for (int p = 0; p < HALF_ELEMS; p++) begin
        if (elems[h*HALF_ELEMS + p][ELEM_WIDTH-2:0] == '0) continue;
        if (filled == 0 && p == int'(POS_LAST)) filled = 1;
        slot       = h * 2 + filled;
        vals[slot] = elems[h*HALF_ELEMS + p];
        pos[slot]  = POS_WIDTH'(p);
        filled++;
        if (filled > 1) break;
      end
    end
    r.kept0      = vals[0];
    r.kept1      = vals[1];
    r.kept2      = vals[2];
    r.kept3      = vals[3];
    r.index_byte = {pos[3], pos[2], pos[1], pos[0]};
    return r;
  endfunction

  function automatic in_word_t pack8(elem_t e0, elem_t e1, elem_t e2, elem_t e3,
                                     elem_t e4, elem_t e5, elem_t e6, elem_t e7);
    in_word_t w;
    w = {e7, e6, e5, e4, e3, e2, e1, e0};
    return w;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic elem_t rand_elem(int zero_pct);
    elem_t specials[8];
    specials = '{16'h0001, 16'h8001, 16'h7FFF, 16'hFFFF,
                 16'h7C00, 16'hFC00, 16'h7E00, 16'h4000};
    if ($urandom_range(0, 99) < zero_pct)
      return $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
    if ($urandom_range(0, 4) == 0)
      return specials[$urandom_range(0, 7)];
    return elem_t'($urandom);
  endfunction

  task automatic push_random_groups(int n);
    int       dens[6];
    int       z0;
    int       z1;
    in_word_t w;
    dens = '{0, 25, 50, 75, 90, 100};
    for (int i = 0; i < n; i++) begin
      z0 = dens[$urandom_range(0, 5)];
      z1 = dens[$urandom_range(0, 5)];
      w  = pack8(rand_elem(z0), rand_elem(z0), rand_elem(z0), rand_elem(z0),
                 rand_elem(z1), rand_elem(z1), rand_elem(z1), rand_elem(z1));
      pending_groups.push_back(w);
    end
    groups_queued += n;
  endtask

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    while (words_checked != groups_queued) @(negedge clk);
  endtask

  // sender: holds a word until taken, then idles or offers the next one
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_groups.size() > 0) begin
        in_ch.data  <= pending_groups.pop_front();
        in_ch.valid <= 1'b1;
        if (tx_burst > 0) begin
          tx_burst--;
        end else begin
          tx_gap = idle_len();
          if ($urandom_range(0, 39) == 0) tx_burst = $urandom_range(30, 120);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      rx_stall = hold_req;
      hold_req = 0;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_burst > 0) begin
        rx_burst--;
      end else begin
        rx_stall = idle_len();
        if ($urandom_range(0, 39) == 0) rx_burst = $urandom_range(30, 120);
      end
    end
  end

  // results are checked before the new word is predicted, so a same-edge result is flagged
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (compressed_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h", $time, out_ch.data);
          mismatches++;
        end else begin
          want = compressed_due.pop_front();
          check_field("kept0", want.kept0, out_ch.data.kept0);
          check_field("kept1", want.kept1, out_ch.data.kept1);
          check_field("kept2", want.kept2, out_ch.data.kept2);
          check_field("kept3", want.kept3, out_ch.data.kept3);
          check_field("index_byte", want.index_byte, out_ch.data.index_byte);
        end
        words_checked++;
      end
      if (in_ch.valid && in_ch.ready) compressed_due.push_back(compress_group(in_ch.data));
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed groups: zeros, -0, extremes, each single position, pairs, surplus
    pending_groups.push_back(pack8(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_groups.push_back(pack8(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                   16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_groups.push_back(pack8(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_groups.push_back(pack8(16'h7FFF, 16'h7FFE, 16'h7FFD, 16'h7FFC,
                                   16'h7FFB, 16'h7FFA, 16'h7FF9, 16'h7FF8));
    pending_groups.push_back(pack8(16'h3C00, 16'h0000, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0001, 16'h0000, 16'h0000));
    pending_groups.push_back(pack8(16'h0000, 16'h0000, 16'h8001, 16'h0000,
                                   16'h0000, 16'h0000, 16'h0000, 16'h7C00));
    pending_groups.push_back(pack8(16'h0000, 16'h0000, 16'h0000, 16'hFC00,
                                   16'h7E00, 16'h0000, 16'h0000, 16'h0000));
    pending_groups.push_back(pack8(16'h1234, 16'h0000, 16'h0000, 16'h4321,
                                   16'h0000, 16'h0000, 16'hABCD, 16'hDCBA));
    pending_groups.push_back(pack8(16'h0000, 16'h5555, 16'hAAAA, 16'h0000,
                                   16'h0F0F, 16'hF0F0, 16'h0000, 16'h0000));
    pending_groups.push_back(pack8(16'h8000, 16'h2222, 16'h8000, 16'h3333,
                                   16'h8000, 16'h8000, 16'h8000, 16'h8001));
    pending_groups.push_back(pack8(16'h1111, 16'h2222, 16'h3333, 16'h0000,
                                   16'h0000, 16'h4444, 16'h5555, 16'h6666));
    pending_groups.push_back(pack8(16'h0000, 16'h0000, 16'h0000, 16'h8000,
                                   16'h0000, 16'h0000, 16'h0000, 16'h4000));
    pending_groups.push_back(pack8(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                   16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    pending_groups.push_back(pack8(16'h7C00, 16'hFC00, 16'h7E00, 16'hFE00,
                                   16'h0001, 16'h8001, 16'h0002, 16'h8002));
    pending_groups.push_back(pack8(16'h0000, 16'h8000, 16'h0000, 16'h0001,
                                   16'h8000, 16'h0000, 16'h8000, 16'hFFFF));
    groups_queued += 15;

    // no new groups are queued until every result is in
    wait_drained();
    @(posedge clk);

    // long receiver hold-off while the sender keeps offering
    push_random_groups(600);
    hold_req = 300;
    wait_drained();
    @(posedge clk);

    push_random_groups(1100);
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/sp24_pkg.sv
hdl/sp24_if.sv
hdl/sp24_lane.sv
hdl/sp24_merge.sv
hdl/sparse_2of4_compressor_core.sv
hdl/sp24_core_chk.sv
dv/sparse_2of4_compressor_core_tb.sv
